[rtl/rlmd_pkg.sv]
// ----------------------------------------------------------------------------
// rlmd_pkg
// Types, codes and constants shared by the run-length move decoder files.
// ----------------------------------------------------------------------------
package rlmd_pkg;

	localparam int CH_W    = 8;
	localparam int REP_W   = 16;
	localparam int MOVES_W = 20;
	localparam int CFG_W   = 20;
	localparam int ADDR_W  = 1;
	localparam int DIG_W   = 4;
	// widest digit-run value: 65535 * 10 + 9 fits in 20 bits
	localparam int VAL_W   = 20;

	// reset values of the configuration registers
	localparam logic [REP_W-1:0]   MAX_REPEAT_RST = 16'd99;
	localparam logic [MOVES_W-1:0] MAX_MOVES_RST  = 20'd4096;

	// register indexes
	localparam logic [ADDR_W-1:0] REG_MAX_REPEAT = 1'd0;
	localparam logic [ADDR_W-1:0] REG_MAX_MOVES  = 1'd1;

	// characters of the record text
	localparam logic [CH_W-1:0] CHAR_0     = 8'h30;
	localparam logic [CH_W-1:0] CHAR_9     = 8'h39;
	localparam logic [CH_W-1:0] CHAR_UP    = 8'h77;  // w
	localparam logic [CH_W-1:0] CHAR_DOWN  = 8'h73;  // s
	localparam logic [CH_W-1:0] CHAR_LEFT  = 8'h61;  // a
	localparam logic [CH_W-1:0] CHAR_RIGHT = 8'h64;  // d

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_EMPTY      = 3'd1,
		ERR_TOO_BIG    = 3'd2,
		ERR_ZERO       = 3'd3,
		ERR_DIGITS_END = 3'd4,
		ERR_BAD_LETTER = 3'd5,
		ERR_TOO_MANY   = 3'd6
	} err_t;

	// decoder state carried from one character to the next
	typedef struct packed {
		logic [REP_W-1:0]   digit_count;
		logic               have_digits;
		logic [MOVES_W-1:0] total_moves;
		logic               at_record_start;
		logic               skipping;
	} state_t;

	localparam state_t STATE_RST = '{
		digit_count:     '0,
		have_digits:     1'b0,
		total_moves:     '0,
		at_record_start: 1'b1,
		skipping:        1'b0
	};

	// one result item
	typedef struct packed {
		logic             run_valid;
		dir_t             direction;
		logic [REP_W-1:0] repeat_res;
		logic             done_res;
		err_t             error;
	} res_t;

	// configuration limits as seen by the decoder
	typedef struct packed {
		logic [REP_W-1:0]   max_repeat;
		logic [MOVES_W-1:0] max_moves;
	} cfg_t;

endpackage

[rtl/rlmd_cfg.sv]
// ----------------------------------------------------------------------------
// rlmd_cfg
// Configuration registers: repeat limit per token and move limit per record.
// ----------------------------------------------------------------------------
module rlmd_cfg import rlmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output cfg_t              cfg
);

	logic [REP_W-1:0]   max_repeat_q;
	logic [MOVES_W-1:0] max_moves_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeat_q <= MAX_REPEAT_RST;
			max_moves_q  <= MAX_MOVES_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MAX_REPEAT: max_repeat_q <= cfg_wdata[REP_W-1:0];
				REG_MAX_MOVES:  max_moves_q  <= cfg_wdata[MOVES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.max_repeat = max_repeat_q;
	assign cfg.max_moves  = max_moves_q;

endmodule

[rtl/rlmd_decode.sv]
// ----------------------------------------------------------------------------
// rlmd_decode
// Single-character decode step: next state and an optional result item.
// ----------------------------------------------------------------------------
module rlmd_decode import rlmd_pkg::*; (
	input  state_t          st,
	input  cfg_t            cfg,
	input  logic [CH_W-1:0] ch,
	input  logic            is_last,
	input  logic            no_char,
	output state_t          st_next,
	output res_t            res,
	output logic            res_valid
);

	logic [CH_W-1:0]    ch_off;
	logic [DIG_W-1:0]   digit;
	logic [VAL_W-1:0]   dc_ext;
	logic [VAL_W-1:0]   value;
	logic [REP_W-1:0]   rep;
	logic [MOVES_W:0]   moves_sum;
	logic               is_digit;
	logic               is_letter;
	dir_t               dir;
	state_t             st_fail;

	// digit value, times-ten as two shifts
	assign ch_off   = ch - CHAR_0;
	assign digit    = ch_off[DIG_W-1:0];
	assign dc_ext   = {{(VAL_W-REP_W){1'b0}}, st.digit_count};
	assign value    = (dc_ext << 3) + (dc_ext << 1) + {{(VAL_W-DIG_W){1'b0}}, digit};
	assign is_digit = (ch >= CHAR_0) && (ch <= CHAR_9);

	// letter decode
	always_comb begin
		is_letter = 1'b1;
		case (ch)
			CHAR_UP:    dir = DIR_UP;
			CHAR_DOWN:  dir = DIR_DOWN;
			CHAR_LEFT:  dir = DIR_LEFT;
			CHAR_RIGHT: dir = DIR_RIGHT;
			default: begin
				dir       = DIR_UP;
				is_letter = 1'b0;
			end
		endcase
	end

	assign rep       = st.have_digits ? st.digit_count : {{(REP_W-1){1'b0}}, 1'b1};
	assign moves_sum = {1'b0, st.total_moves} + {{(MOVES_W+1-REP_W){1'b0}}, rep};

	// state after an error: skip the rest unless this item ends the text
	always_comb begin
		st_fail          = STATE_RST;
		st_fail.skipping = !is_last;
	end

	// one step of the record parser
	always_comb begin
		st_next        = st;
		res_valid      = 1'b0;
		res.run_valid  = 1'b0;
		res.direction  = DIR_UP;
		res.repeat_res = '0;
		res.done_res   = 1'b1;
		res.error      = ERR_OK;

		if (st.skipping) begin
			if (is_last)
				st_next = STATE_RST;
		end else if (no_char) begin
			if (is_last) begin
				res_valid = 1'b1;
				st_next   = STATE_RST;
				if (st.at_record_start)
					res.error = ERR_EMPTY;
				else if (st.have_digits)
					res.error = (st.digit_count == '0) ? ERR_ZERO : ERR_DIGITS_END;
			end
		end else if (is_digit) begin
			if (value > {{(VAL_W-REP_W){1'b0}}, cfg.max_repeat}) begin
				res_valid = 1'b1;
				res.error = ERR_TOO_BIG;
				st_next   = st_fail;
			end else if (is_last) begin
				res_valid = 1'b1;
				res.error = (value == '0) ? ERR_ZERO : ERR_DIGITS_END;
				st_next   = STATE_RST;
			end else begin
				st_next.digit_count     = value[REP_W-1:0];
				st_next.have_digits     = 1'b1;
				st_next.at_record_start = 1'b0;
			end
		end else if (st.have_digits && (st.digit_count == '0)) begin
			res_valid = 1'b1;
			res.error = ERR_ZERO;
			st_next   = st_fail;
		end else if (!is_letter) begin
			res_valid = 1'b1;
			res.error = ERR_BAD_LETTER;
			st_next   = st_fail;
		end else if (moves_sum > {1'b0, cfg.max_moves}) begin
			res_valid = 1'b1;
			res.error = ERR_TOO_MANY;
			st_next   = st_fail;
		end else begin
			// emit the run
			res_valid      = 1'b1;
			res.run_valid  = 1'b1;
			res.direction  = dir;
			res.repeat_res = rep;
			res.done_res   = is_last;
			if (is_last) begin
				st_next = STATE_RST;
			end else begin
				st_next.total_moves     = moves_sum[MOVES_W-1:0];
				st_next.digit_count     = '0;
				st_next.have_digits     = 1'b0;
				st_next.at_record_start = 1'b0;
			end
		end
	end

endmodule

[rtl/run_length_move_decoder.sv]
// ----------------------------------------------------------------------------
// run_length_move_decoder
// Decodes a character stream of counted w/s/a/d tokens into direction runs.
// ----------------------------------------------------------------------------
// Path: the accepting edge loads the input register; the result register is
//   loaded as the character leaves it, which waits while a result meets a
//   full result register that m_tready stalls.
// Throughput: one character per cycle unless such a stall holds it; the
//   decode step between the two registers is combinational.
// Reset: arst_n clears all control state, sets the limits to 99 and 4096
//   and starts a fresh record; no clearing pass is needed.
module run_length_move_decoder import rlmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// character stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] ch
	input  logic              s_tlast,   // is_last
	input  logic              s_tuser,   // [0] no_char
	// run stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [1:0] direction, [17:2] repeat_res,
	                                     // [20:18] error, [23:21] zero
	output logic              m_tlast,   // done_res
	output logic              m_tuser    // [0] run_valid
);

	cfg_t            cfg;
	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            last_s1;
	logic            nochar_s1;
	state_t          state_q;
	state_t          state_next;
	res_t            res;
	logic            res_valid;
	logic            out_valid_q;
	res_t            out_res_q;
	logic            out_free;
	logic            adv_s1;
	logic            s_accept;

	rlmd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rlmd_decode u_decode (
		.st        (state_q),
		.cfg       (cfg),
		.ch        (ch_s1),
		.is_last   (last_s1),
		.no_char   (nochar_s1),
		.st_next   (state_next),
		.res       (res),
		.res_valid (res_valid)
	);

	// pipeline flow control
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_accept = s_tvalid && s_tready;

	// input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			ch_s1     <= s_tdata;
			last_s1   <= s_tlast;
			nochar_s1 <= s_tuser;
		end
	end

	// advance the parser state as the character leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	// result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid)
			out_res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_res_q.error, out_res_q.repeat_res, out_res_q.direction};
	assign m_tlast  = out_res_q.done_res;
	assign m_tuser  = out_res_q.run_valid;

endmodule

[rtl/rlmd_checker.sv]
// ----------------------------------------------------------------------------
// rlmd_checker
// Port-level checks on the run stream of the move decoder, bound to the top.
// ----------------------------------------------------------------------------
module rlmd_checker import rlmd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// an error transaction ends the record and carries no run
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:18] != ERR_OK) |->
			m_tlast && !m_tuser && (m_tdata[17:0] == 18'd0))
	else $error("error transaction with run data or without done");

	// a transaction without a run always ends the record
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
	else $error("non-run transaction without done");

	// a run carries a nonzero repeat and no error
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[17:2] != 16'd0) && (m_tdata[20:18] == ERR_OK))
	else $error("run with zero repeat or with an error code");

	// a stalled transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
	else $error("stalled result changed");

endmodule

bind run_length_move_decoder rlmd_checker u_rlmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
